// ===== rtl/wtsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave table sound channel package
// Shared codes, register offsets, the wave ram write port and the level table.
// ----------------------------------------------------------------------------
package wtsc_pkg;

   localparam int WAVE_ENTRIES = 32;
   localparam int WAVE_BYTES   = WAVE_ENTRIES / 2;
   localparam int WAVE_AW      = $clog2(WAVE_BYTES);

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2,
      OP_FRAME = 2'd3
   } wtsc_op_type;

   localparam logic [4:0] REG_DAC       = 5'd0;
   localparam logic [4:0] REG_LENGTH    = 5'd1;
   localparam logic [4:0] REG_VOLUME    = 5'd2;
   localparam logic [4:0] REG_PERIOD_LO = 5'd3;
   localparam logic [4:0] REG_PERIOD_HI = 5'd4;

   typedef struct packed {
      logic               en;
      logic [WAVE_AW-1:0] addr;
      logic [7:0]         data;
   } wtsc_wr_type;

   // trunc(k * vol * 8192 / 225) for odd k = 1..15, one row per volume code
   localparam logic [13:0] LEVEL_MAG [4][8] = '{
      '{14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0},
      '{14'd546,  14'd1638, 14'd2730, 14'd3822, 14'd4915, 14'd6007, 14'd7099, 14'd8192},
      '{14'd291,  14'd873,  14'd1456, 14'd2038, 14'd2621, 14'd3203, 14'd3786, 14'd4369},
      '{14'd145,  14'd436,  14'd728,  14'd1019, 14'd1310, 14'd1601, 14'd1893, 14'd2184}
   };

   // signed output level of one wave nibble at a volume code
   function automatic logic signed [14:0] wave_level(logic [3:0] w, logic [1:0] code);
      logic [2:0]  j;
      logic [14:0] mag;
      j   = w[3] ? w[2:0] : ~w[2:0];
      mag = {1'b0, LEVEL_MAG[code][j]};
      return w[3] ? mag : 15'(-mag);
   endfunction

endpackage

// ===== rtl/wtsc_wave_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave table ram
// Byte-wide wave storage, one write and two registered reads per cycle, with
// per-byte valid bits for the all-zero reset and same-cycle write bypass.
// ----------------------------------------------------------------------------
module wtsc_wave_ram (
   input  logic                          clock,
   input  logic                          reset,
   input  wtsc_pkg::wtsc_wr_type         wr,
   input  logic                          rd_en,
   input  logic [wtsc_pkg::WAVE_AW-1:0]  rd_addr_a,
   input  logic [wtsc_pkg::WAVE_AW-1:0]  rd_addr_b,
   output logic [7:0]                    rd_data_a,
   output logic [7:0]                    rd_data_b
);
   import wtsc_pkg::*;

   logic [7:0]            mem [WAVE_BYTES];
   logic [WAVE_BYTES-1:0] vld_ff;

   logic [7:0] data_a_ff, data_b_ff, byp_data_ff;
   logic       vld_a_ff, vld_b_ff, byp_a_ff, byp_b_ff;
   logic       byp_a_in, byp_b_in;

   assign byp_a_in = wr.en && (wr.addr == rd_addr_a);
   assign byp_b_in = wr.en && (wr.addr == rd_addr_b);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff   <= mem[rd_addr_a];
         data_b_ff   <= mem[rd_addr_b];
         vld_a_ff    <= vld_ff[rd_addr_a];
         vld_b_ff    <= vld_ff[rd_addr_b];
         byp_a_ff    <= byp_a_in;
         byp_b_ff    <= byp_b_in;
         byp_data_ff <= wr.data;
      end
   end

   // a byte never written reads as zero
   assign rd_data_a = byp_a_ff ? byp_data_ff : (vld_a_ff ? data_a_ff : 8'd0);
   assign rd_data_b = byp_b_ff ? byp_data_ff : (vld_b_ff ? data_b_ff : 8'd0);

endmodule

// ===== rtl/wave_table_sound_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave table sound channel
// Register writes and reads, timer ticks and frame steps on one request
// channel; every request returns read data, the current sample and status.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  req_     | in        | req_valid/req_stall | operation, reg_address, write_data, div_step
//  rsp_     | out       | rsp_valid/rsp_stall | read_data, sample, channel_on
//
// one request per cycle while req_stall is low; taking a request registers the decoded
// request and the wave ram read in stage one, and stage one then moves with the level
// lookup into the output register, which offers the response.
// the two-entry pipe keeps accepting while rsp_stall holds a response, until both
// entries are full. synchronous reset clears all control state; the wave ram
// reads as zero through per-byte valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module wave_table_sound_channel (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [4:0]         req_reg_address,
   input  logic [7:0]         req_write_data,
   input  logic [2:0]         req_div_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_read_data,
   output logic signed [14:0] rsp_sample,
   output logic               rsp_channel_on
);
   import wtsc_pkg::*;

   // channel state
   logic        dac_ff, dac_in;
   logic        play_ff, play_in;
   logic        len_en_ff, len_en_in;
   logic [10:0] period_ff, period_in;
   logic [12:0] timer_ff, timer_in;
   logic [4:0]  pos_ff, pos_in;
   logic [8:0]  len_ff, len_in;
   logic [1:0]  start_vol_ff, start_vol_in;
   logic [1:0]  live_vol_ff, live_vol_in;

   // pipeline
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_wave_rd_ff;
   logic [7:0] s1_rd_val_ff;
   logic       s1_snd_en_ff;
   logic       s1_nib_lo_ff;
   logic [1:0] s1_vol_ff;
   logic       s1_on_ff;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_rd_ff;
   logic signed [14:0] out_sample_ff;
   logic              out_on_ff;

   logic        accept, out_free, s1_move;
   wtsc_op_type op;
   logic [7:0]  reg_rd_val;
   logic        trigger;
   wtsc_wr_type ram_wr;
   logic [7:0]  ram_rd_a, ram_rd_b;
   logic [3:0]  nib;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign op        = wtsc_op_type'(req_operation);

   assign trigger = req_write_data[7] && !play_ff && dac_ff;

   always_comb begin
      dac_in       = dac_ff;
      play_in      = play_ff;
      len_en_in    = len_en_ff;
      period_in    = period_ff;
      timer_in     = timer_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      start_vol_in = start_vol_ff;
      live_vol_in  = live_vol_ff;
      unique case (op)
         OP_WRITE: begin
            if (!req_reg_address[4]) begin
               unique case (req_reg_address)
                  REG_DAC: begin
                     dac_in  = req_write_data[7];
                     play_in = play_ff && req_write_data[7];
                  end
                  REG_LENGTH: begin
                     len_in = 9'd256 - {1'b0, req_write_data};
                  end
                  REG_VOLUME: begin
                     start_vol_in = req_write_data[6:5];
                     live_vol_in  = req_write_data[6:5];
                  end
                  REG_PERIOD_LO: begin
                     period_in[7:0] = req_write_data;
                  end
                  REG_PERIOD_HI: begin
                     period_in[10:8] = req_write_data[2:0];
                     len_en_in       = req_write_data[6];
                     if (trigger) begin
                        play_in     = 1'b1;
                        timer_in    = '0;
                        live_vol_in = start_vol_ff;
                        pos_in      = '0;
                        if (len_ff == 9'd0) begin
                           len_in = 9'd256;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_READ: begin
         end
         OP_TICK: begin
            if (play_ff && dac_ff) begin
               if (timer_ff == 13'd0) begin
                  pos_in   = pos_ff + 5'd1;
                  // reload is 2 * (2048 - period), 4096 at period zero
                  timer_in = {12'd2048 - {1'b0, period_ff}, 1'b0};
               end else begin
                  timer_in = timer_ff - 13'd1;
               end
            end
         end
         OP_FRAME: begin
            if (play_ff && dac_ff && len_en_ff && !req_div_step[0] && len_ff != 9'd0) begin
               len_in = len_ff - 9'd1;
               if (len_ff == 9'd1) begin
                  play_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (req_reg_address)
         REG_DAC:    reg_rd_val = {dac_ff, 7'd0};
         REG_VOLUME: reg_rd_val = {1'b0, start_vol_ff, 5'd0};
         REG_PERIOD_HI: reg_rd_val = {1'b0, len_en_ff, 6'd0};
         default:    reg_rd_val = 8'hFF;
      endcase
   end

   assign ram_wr.en   = accept && (op == OP_WRITE) && req_reg_address[4];
   assign ram_wr.addr = req_reg_address[WAVE_AW-1:0];
   assign ram_wr.data = req_write_data;

   wtsc_wave_ram u_ram (
      .clock     (clock),
      .reset     (reset),
      .wr        (ram_wr),
      .rd_en     (accept),
      .rd_addr_a (req_reg_address[WAVE_AW-1:0]),
      .rd_addr_b (pos_in[4:1]),
      .rd_data_a (ram_rd_a),
      .rd_data_b (ram_rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dac_ff       <= 1'b0;
         play_ff      <= 1'b0;
         len_en_ff    <= 1'b0;
         period_ff    <= '0;
         timer_ff     <= '0;
         pos_ff       <= '0;
         len_ff       <= 9'd256;
         start_vol_ff <= '0;
         live_vol_ff  <= '0;
      end else if (accept) begin
         dac_ff       <= dac_in;
         play_ff      <= play_in;
         len_en_ff    <= len_en_in;
         period_ff    <= period_in;
         timer_ff     <= timer_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         start_vol_ff <= start_vol_in;
         live_vol_ff  <= live_vol_in;
      end
   end

   assign s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage one: request decoded, state updated, ram read in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_wave_rd_ff <= (op == OP_READ) && req_reg_address[4];
         s1_rd_val_ff  <= (op == OP_READ) ? reg_rd_val : 8'd0;
         s1_snd_en_ff  <= play_in && dac_in;
         s1_nib_lo_ff  <= pos_in[0];
         s1_vol_ff     <= live_vol_in;
         s1_on_ff      <= play_in;
      end
   end

   // even positions take the high nibble
   assign nib = s1_nib_lo_ff ? ram_rd_b[3:0] : ram_rd_b[7:4];

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_rd_ff     <= s1_wave_rd_ff ? ram_rd_a : s1_rd_val_ff;
         out_sample_ff <= s1_snd_en_ff ? wave_level(nib, s1_vol_ff) : 15'sd0;
         out_on_ff     <= s1_on_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_data  = out_rd_ff;
   assign rsp_sample     = out_sample_ff;
   assign rsp_channel_on = out_on_ff;

endmodule

// ===== rtl/wtsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave table sound channel checker
// Port-level properties of the sound channel, bound to the top level.
// ----------------------------------------------------------------------------
module wtsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_read_data,
   input logic signed [14:0] rsp_sample,
   input logic               rsp_channel_on
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) &&
      $stable(rsp_sample) && $stable(rsp_channel_on))
      else $error("stalled response changed");

   // with the output register empty there is always room for a request
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // a silent channel gives a zero sample
   a_off_is_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_channel_on |-> rsp_sample == 15'sd0)
      else $error("sample nonzero while channel off");

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample >= -15'sd8192 && rsp_sample <= 15'sd8192)
      else $error("sample out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind wave_table_sound_channel wtsc_checker u_wtsc_checker (.*);

// ===== test/wave_table_sound_channel_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave table sound channel testbench
// Drives register writes and reads, timer ticks and frame steps through the
// request channel. A behavioral copy of the channel predicts read data, sample
// and status for every request, and each response is compared in order.
// Directed tests cover the register map, trigger, length expiry and the full
// timer reload. A long random phase follows, with request gaps and response stalls.
// ----------------------------------------------------------------------------
module wave_table_sound_channel_test;
   import wtsc_pkg::*;

   localparam logic [4:0] WAVE_BASE_ADDR = 5'd16;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic [7:0]         read_data;
      logic signed [14:0] sample;
      logic               channel_on;
   } channel_out_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_operation;
   logic [4:0]         req_reg_address;
   logic [7:0]         req_write_data;
   logic [2:0]         req_div_step;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_read_data;
   logic signed [14:0] rsp_sample;
   logic               rsp_channel_on;

   // predicted channel state
   logic [3:0]  wave_nibbles [WAVE_ENTRIES];
   logic        dac_enabled;
   logic        chan_active;
   logic        length_gate;
   logic [10:0] period_reg;
   logic [12:0] timer_count;
   logic [4:0]  wave_pos;
   logic [8:0]  length_left;
   logic [1:0]  volume_code;
   logic [3:0]  live_volume;

   channel_out_type expected_outputs[$];

   int error_count;
   int requests_sent;
   int responses_checked;
   int active_responses;
   int wave_steps;
   int length_expiries;
   int idle_cycles;
   bit sender_gaps;
   int unsigned stall_run = 0;
   logic stall_level = 1'b0;

   wave_table_sound_channel i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_reg_address (req_reg_address),
      .req_write_data  (req_write_data),
      .req_div_step    (req_div_step),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_sample      (rsp_sample),
      .rsp_channel_on  (rsp_channel_on)
   );

   always #10 clock = ~clock;

   function automatic logic [3:0] volume_of_code(input logic [1:0] code);
      case (code)
         2'd1:    return 4'd15;
         2'd2:    return 4'd8;
         2'd3:    return 4'd4;
         default: return 4'd0;
      endcase
   endfunction

   function automatic logic signed [14:0] level_of(input logic [3:0] nib, input logic [3:0] vol);
      int num;
      num = (2 * int'(nib) - 15) * int'(vol) * 8192;
      return 15'(num / 225);
   endfunction

   function automatic void reset_channel_state();
      foreach (wave_nibbles[i]) wave_nibbles[i] = 4'd0;
      dac_enabled = 1'b0;
      chan_active = 1'b0;
      length_gate = 1'b0;
      period_reg  = '0;
      timer_count = '0;
      wave_pos    = '0;
      length_left = 9'd256;
      volume_code = 2'd0;
      live_volume = 4'd0;
   endfunction

   // update the predicted state with one request and queue its response
   function automatic void apply_request(input wtsc_op_type op, input logic [4:0] addr,
                                         input logic [7:0] data, input logic [2:0] step);
      channel_out_type o;
      logic [4:0]      idx;
      o.read_data = 8'd0;
      idx = {addr[3:0], 1'b0};
      case (op)
         OP_WRITE: begin
            if (addr >= WAVE_BASE_ADDR) begin
               wave_nibbles[idx]        = data[7:4];
               wave_nibbles[idx + 5'd1] = data[3:0];
            end else begin
               case (addr)
                  REG_DAC: begin
                     dac_enabled = data[7];
                     if (!data[7]) chan_active = 1'b0;
                  end
                  REG_LENGTH: length_left = 9'(9'd256 - data);
                  REG_VOLUME: begin
                     volume_code = data[6:5];
                     live_volume = volume_of_code(data[6:5]);
                  end
                  REG_PERIOD_LO: period_reg[7:0] = data;
                  REG_PERIOD_HI: begin
                     period_reg[10:8] = data[2:0];
                     length_gate = data[6];
                     // trigger only restarts an idle channel with the dac on
                     if (data[7] && !chan_active && dac_enabled) begin
                        chan_active = 1'b1;
                        timer_count = '0;
                        wave_pos    = '0;
                        live_volume = volume_of_code(volume_code);
                        if (length_left == 9'd0) length_left = 9'd256;
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_READ: begin
            if (addr >= WAVE_BASE_ADDR) begin
               o.read_data = {wave_nibbles[idx], wave_nibbles[idx + 5'd1]};
            end else begin
               case (addr)
                  REG_DAC:       o.read_data = {dac_enabled, 7'd0};
                  REG_VOLUME:    o.read_data = {1'b0, volume_code, 5'd0};
                  REG_PERIOD_HI: o.read_data = {1'b0, length_gate, 6'd0};
                  default:       o.read_data = 8'hFF;
               endcase
            end
         end
         OP_TICK: begin
            if (chan_active && dac_enabled) begin
               if (timer_count == 13'd0) begin
                  wave_pos    = wave_pos + 5'd1;
                  timer_count = 13'((2048 - int'(period_reg)) * 2);
                  wave_steps++;
               end else begin
                  timer_count = timer_count - 13'd1;
               end
            end
         end
         default: begin
            if (chan_active && dac_enabled && length_gate && !step[0] &&
                length_left != 9'd0) begin
               length_left = length_left - 9'd1;
               if (length_left == 9'd0) begin
                  chan_active = 1'b0;
                  length_expiries++;
               end
            end
         end
      endcase
      o.sample     = (chan_active && dac_enabled) ? level_of(wave_nibbles[wave_pos], live_volume)
                                                  : 15'sd0;
      o.channel_on = chan_active;
      if (chan_active) active_responses++;
      expected_outputs.push_back(o);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("response %0d: %s is %0d, expected %0d", responses_checked, what, got, want);
   endtask

   // request side idle; payload is scrambled while valid is low
   task automatic idle_requests(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid       <= 1'b0;
         req_operation   <= 2'($urandom);
         req_reg_address <= 5'($urandom);
         req_write_data  <= 8'($urandom);
         req_div_step    <= 3'($urandom);
      end
   endtask

   task automatic random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (!sender_gaps || pick < 55) return;
      if (pick < 88) idle_requests($urandom_range(1, 2));
      else if (pick < 97) idle_requests($urandom_range(3, 8));
      else idle_requests($urandom_range(20, 60));
   endtask

   task automatic send_request(input wtsc_op_type op, input logic [4:0] addr,
                               input logic [7:0] data, input logic [2:0] step);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_reg_address <= addr;
      req_write_data  <= data;
      req_div_step    <= step;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(op, addr, data, step);
      requests_sent++;
      random_gap();
   endtask

   task automatic wait_all_responses();
      idle_requests(1);
      while (expected_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic test_reset_values();
      send_request(OP_READ, REG_DAC, 8'h00, 3'd0);
      send_request(OP_READ, REG_LENGTH, 8'h00, 3'd0);
      send_request(OP_READ, REG_VOLUME, 8'h00, 3'd0);
      send_request(OP_READ, REG_PERIOD_HI, 8'h00, 3'd0);
      send_request(OP_READ, WAVE_BASE_ADDR, 8'h00, 3'd0);
   endtask

   task automatic test_register_map();
      send_request(OP_WRITE, 5'd9, 8'hFF, 3'd7);
      send_request(OP_READ, 5'd9, 8'hFF, 3'd7);
      send_request(OP_WRITE, WAVE_BASE_ADDR, 8'h0F, 3'd0);
      send_request(OP_WRITE, 5'd31, 8'hF0, 3'd0);
      send_request(OP_READ, 5'd31, 8'h00, 3'd0);
      send_request(OP_WRITE, REG_VOLUME, 8'h60, 3'd0);
      send_request(OP_READ, REG_VOLUME, 8'h00, 3'd0);
      send_request(OP_WRITE, REG_VOLUME, 8'h20, 3'd0);
   endtask

   task automatic test_trigger_and_play();
      // trigger with the dac off does nothing
      send_request(OP_WRITE, REG_PERIOD_HI, 8'h80, 3'd0);
      send_request(OP_WRITE, REG_DAC, 8'h80, 3'd0);
      send_request(OP_WRITE, REG_PERIOD_LO, 8'hFF, 3'd0);
      send_request(OP_WRITE, REG_PERIOD_HI, 8'hC7, 3'd0);
      repeat (4) send_request(OP_TICK, 5'd0, 8'h00, 3'd0);
      // retrigger while playing is ignored
      send_request(OP_WRITE, REG_PERIOD_HI, 8'h87, 3'd0);
      send_request(OP_WRITE, REG_DAC, 8'h7F, 3'd0);
   endtask

   task automatic test_length_expiry();
      send_request(OP_WRITE, REG_DAC, 8'h80, 3'd0);
      send_request(OP_WRITE, REG_LENGTH, 8'hFF, 3'd0);
      send_request(OP_WRITE, REG_PERIOD_HI, 8'hC7, 3'd0);
      send_request(OP_FRAME, 5'd0, 8'h00, 3'd1);
      send_request(OP_FRAME, 5'd0, 8'h00, 3'd0);
      send_request(OP_FRAME, 5'd0, 8'h00, 3'd6);
      // count at zero reloads to full on trigger
      send_request(OP_WRITE, REG_PERIOD_HI, 8'hC7, 3'd0);
      send_request(OP_READ, REG_PERIOD_HI, 8'h00, 3'd0);
      send_request(OP_FRAME, 5'd0, 8'h00, 3'd2);
   endtask

   // period zero reloads the timer to 4096, one step past 12 bits
   task automatic test_full_period_reload();
      wait_all_responses();
      send_request(OP_WRITE, REG_DAC, 8'h00, 3'd0);
      send_request(OP_WRITE, REG_DAC, 8'h80, 3'd0);
      send_request(OP_WRITE, REG_VOLUME, 8'h60, 3'd0);
      send_request(OP_WRITE, WAVE_BASE_ADDR, 8'h5A, 3'd0);
      send_request(OP_WRITE, 5'd17, 8'h3C, 3'd0);
      send_request(OP_WRITE, REG_PERIOD_LO, 8'h00, 3'd0);
      send_request(OP_WRITE, REG_PERIOD_HI, 8'h80, 3'd0);
      repeat (12) send_request(OP_TICK, 5'($urandom), 8'($urandom), 3'($urandom));
   endtask

   task automatic test_random_traffic();
      int          stop_at;
      int unsigned pick;
      int unsigned kind;
      stop_at = requests_sent + RANDOM_ITEMS;
      while (requests_sent < stop_at) begin
         sender_gaps = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // set up the channel, trigger it and let it run
            repeat ($urandom_range(0, 4))
               send_request(OP_WRITE, 5'(16 + $urandom_range(0, 15)), 8'($urandom),
                            3'($urandom));
            if ($urandom_range(0, 1) == 0)
               send_request(OP_WRITE, REG_DAC, {1'b0, 7'($urandom)}, 3'($urandom));
            send_request(OP_WRITE, REG_DAC, {($urandom_range(0, 7) != 0), 7'($urandom)},
                         3'($urandom));
            send_request(OP_WRITE, REG_VOLUME, 8'($urandom), 3'($urandom));
            send_request(OP_WRITE, REG_LENGTH,
                         ($urandom_range(0, 1) == 0) ? 8'($urandom_range(248, 255))
                                                     : 8'($urandom), 3'($urandom));
            send_request(OP_WRITE, REG_PERIOD_LO,
                         ($urandom_range(0, 9) < 7) ? 8'($urandom_range(240, 255))
                                                    : 8'($urandom), 3'($urandom));
            send_request(OP_WRITE, REG_PERIOD_HI,
                         {1'b1, 1'($urandom), 3'($urandom),
                          ($urandom_range(0, 3) != 0) ? 3'd7 : 3'($urandom)}, 3'($urandom));
            repeat ($urandom_range(10, 40)) begin
               kind = $urandom_range(0, 99);
               if (kind < 65)
                  send_request(OP_TICK, 5'($urandom), 8'($urandom), 3'($urandom));
               else if (kind < 82)
                  send_request(OP_FRAME, 5'($urandom), 8'($urandom), 3'($urandom));
               else if (kind < 95)
                  send_request(OP_READ, 5'($urandom), 8'($urandom), 3'($urandom));
               else
                  send_request(OP_WRITE, 5'($urandom), 8'($urandom), 3'($urandom));
            end
         end else if (pick < 90) begin
            repeat ($urandom_range(5, 15))
               send_request(wtsc_op_type'($urandom_range(0, 3)), 5'($urandom),
                            8'($urandom), 3'($urandom));
         end else begin
            // cut a running channel short or trigger out of order
            send_request(OP_WRITE, REG_PERIOD_HI, {1'b1, 7'($urandom)}, 3'($urandom));
            repeat ($urandom_range(1, 6))
               send_request(OP_TICK, 5'($urandom), 8'($urandom), 3'($urandom));
            send_request(OP_WRITE, REG_DAC, 8'($urandom), 3'($urandom));
            send_request(OP_TICK, 5'($urandom), 8'($urandom), 3'($urandom));
         end
         if ($urandom_range(0, 9) == 0) wait_all_responses();
      end
   endtask

   // response stall: runs of no stall, short stalls, and now and then a long one
   always @(negedge clock) begin : drive_rsp_stall
      int unsigned pick;
      if (stall_run == 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            stall_level = 1'b0;
            stall_run   = $urandom_range(1, 40);
         end else if (pick < 85) begin
            stall_level = 1'b1;
            stall_run   = $urandom_range(1, 3);
         end else if (pick < 97) begin
            stall_level = 1'b1;
            stall_run   = $urandom_range(4, 15);
         end else begin
            stall_level = 1'b1;
            stall_run   = $urandom_range(30, 80);
         end
      end
      stall_run = stall_run - 1;
      rsp_stall <= stall_level;
   end

   always @(posedge clock) begin : check_responses
      channel_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            report_mismatch("unexpected response, read_data", int'(rsp_read_data), -1);
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", int'(rsp_read_data), int'(want.read_data));
            if (rsp_sample !== want.sample)
               report_mismatch("sample", int'(rsp_sample), int'(want.sample));
            if (rsp_channel_on !== want.channel_on)
               report_mismatch("channel_on", int'(rsp_channel_on), int'(want.channel_on));
         end
         responses_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no request or response moved for %0d cycles", WATCHDOG_LIMIT);
         $display("[wave_table_sound_channel] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_WRITE;
      req_reg_address = 5'd0;
      req_write_data  = 8'd0;
      req_div_step    = 3'd0;
      sender_gaps     = 1'b1;
      reset_channel_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_register_map();
      test_trigger_and_play();
      test_length_expiry();
      test_full_period_reload();
      test_random_traffic();

      wait_all_responses();
      repeat (8) @(posedge clock);
      $display("%0d requests, %0d responses checked, %0d with the channel on",
               requests_sent, responses_checked, active_responses);
      $display("%0d wave steps and %0d length expiries seen", wave_steps, length_expiries);
      if (error_count == 0) begin
         $display("[wave_table_sound_channel] OK");
      end else begin
         $display("[wave_table_sound_channel] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/wtsc_pkg.sv
rtl/wtsc_wave_ram.sv
rtl/wave_table_sound_channel.sv
rtl/wtsc_checker.sv
test/wave_table_sound_channel_test.sv
